// ----- hdl/ualu_pkg.sv -----
// ----------------------------------------------------------------------------
// ualu_pkg
// Shared widths, operation and condition codes, and the condition evaluator
// for the single-operand ALU with XNZVC condition codes.
// ----------------------------------------------------------------------------
package ualu_pkg;

  localparam int DATA_W  = 32;
  localparam int REQ_W   = 4;
  localparam int SIZE_W  = 2;
  localparam int CC_W    = 4;
  localparam int FLAGS_W = 5;

  // flag bit positions, XNZVC
  localparam int FL_X = 4;
  localparam int FL_N = 3;
  localparam int FL_Z = 2;
  localparam int FL_V = 1;
  localparam int FL_C = 0;

  typedef enum logic [REQ_W-1:0] {
    REQ_NEG        = 4'd0,
    REQ_NEGX       = 4'd1,
    REQ_NOT        = 4'd2,
    REQ_CLR        = 4'd3,
    REQ_TST        = 4'd4,
    REQ_NBCD       = 4'd5,
    REQ_TAS        = 4'd6,
    REQ_SWAP       = 4'd7,
    REQ_EXT        = 4'd8,
    REQ_LOAD_FLAGS = 4'd9,
    REQ_COND_TEST  = 4'd10,
    REQ_MOVE_FLAGS = 4'd11
  } req_code_t;

  typedef enum logic [SIZE_W-1:0] {
    SZ_BYTE = 2'd0,
    SZ_WORD = 2'd1,
    SZ_LONG = 2'd2
  } size_code_t;

  typedef enum logic [CC_W-1:0] {
    CC_T  = 4'd0,
    CC_F  = 4'd1,
    CC_HI = 4'd2,
    CC_LS = 4'd3,
    CC_CC = 4'd4,
    CC_CS = 4'd5,
    CC_NE = 4'd6,
    CC_EQ = 4'd7,
    CC_VC = 4'd8,
    CC_VS = 4'd9,
    CC_PL = 4'd10,
    CC_MI = 4'd11,
    CC_GE = 4'd12,
    CC_LT = 4'd13,
    CC_GT = 4'd14,
    CC_LE = 4'd15
  } cond_code_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [SIZE_W-1:0] op_size;
    logic [DATA_W-1:0] operand;
    logic [CC_W-1:0]   cond_code;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  value;
    logic [FLAGS_W-1:0] flags;
    logic               cond;
  } res_t;

  // Condition test against XNZVC; the false slot counts as true here.
  function automatic logic cond_eval(input logic [CC_W-1:0] cc,
                                     input logic [FLAGS_W-1:0] f);
    logic c, z, v, n, t;
    c = f[FL_C];
    z = f[FL_Z];
    v = f[FL_V];
    n = f[FL_N];
    unique case (cc)
      CC_T, CC_F: t = 1'b1;
      CC_HI:      t = !c && !z;
      CC_LS:      t = c || z;
      CC_CC:      t = !c;
      CC_CS:      t = c;
      CC_NE:      t = !z;
      CC_EQ:      t = z;
      CC_VC:      t = !v;
      CC_VS:      t = v;
      CC_PL:      t = !n;
      CC_MI:      t = n;
      CC_GE:      t = (n == v);
      CC_LT:      t = (n != v);
      CC_GT:      t = (n == v) && !z;
      CC_LE:      t = (n != v) || z;
      default:    t = 1'b1;
    endcase
    return t;
  endfunction

endpackage

// ----- hdl/ualu_exec.sv -----
// ----------------------------------------------------------------------------
// ualu_exec
// Combinational execute step: result value, new flags and condition outcome
// for one operation against the current flag register.
// ----------------------------------------------------------------------------
module ualu_exec (
  input  ualu_pkg::req_t                    req,
  input  logic [ualu_pkg::FLAGS_W-1:0]      flags,
  output ualu_pkg::res_t                    res
);
  import ualu_pkg::*;

  logic [DATA_W-1:0]  mask;
  logic [DATA_W-1:0]  sign;
  logic [DATA_W-1:0]  u;
  logic               x;
  logic [DATA_W-1:0]  neg_v;
  logic [DATA_W-1:0]  negx_v;
  logic [DATA_W-1:0]  not_v;
  logic [DATA_W-1:0]  swap_v;
  logic [15:0]        ext_w;
  logic [DATA_W-1:0]  ext_l;
  logic [7:0]         tas_b;

  // decimal negate datapath
  logic [7:0]         bcd_dec;
  logic [8:0]         bcd_raw;
  logic [8:0]         bcd_res;
  logic               bcd_neg;
  logic [8:0]         bcd_abs;
  logic [6:0]         bcd_mag;
  logic [14:0]        bcd_prod;
  logic [3:0]         bcd_q;
  logic [3:0]         bcd_r;
  logic [7:0]         bcd_q8;
  logic [7:0]         bcd_r8;
  logic [7:0]         bcd_v;
  logic               bcd_borrow;

  logic [DATA_W-1:0]  v;
  logic [FLAGS_W-1:0] f;

  // keep X, set N and Z from the sized value, clear V and C
  function automatic logic [FLAGS_W-1:0] nz_flags(input logic [FLAGS_W-1:0] fi,
                                                  input logic [DATA_W-1:0] val,
                                                  input logic [DATA_W-1:0] sgn);
    logic [FLAGS_W-1:0] fo;
    fo       = '0;
    fo[FL_X] = fi[FL_X];
    fo[FL_N] = |(val & sgn);
    fo[FL_Z] = (val == '0);
    return fo;
  endfunction

  always_comb begin
    unique case (req.op_size)
      SZ_BYTE: begin
        mask = 32'h0000_00ff;
        sign = 32'h0000_0080;
      end
      SZ_WORD: begin
        mask = 32'h0000_ffff;
        sign = 32'h0000_8000;
      end
      default: begin
        mask = 32'hffff_ffff;
        sign = 32'h8000_0000;
      end
    endcase
  end

  assign u      = req.operand & mask;
  assign x      = flags[FL_X];
  assign neg_v  = (32'd0 - u) & mask;
  assign negx_v = (32'd0 - u - {31'd0, x}) & mask;
  assign not_v  = ~u & mask;
  assign swap_v = {req.operand[15:0], req.operand[31:16]};
  assign ext_w  = {{8{req.operand[7]}}, req.operand[7:0]};
  assign ext_l  = {{16{req.operand[15]}}, req.operand[15:0]};
  assign tas_b  = req.operand[7:0];

  // 100 - (10*hi + lo) - X, digits by truncating division toward zero
  assign bcd_dec    = ({4'd0, req.operand[7:4]} << 3) + ({4'd0, req.operand[7:4]} << 1)
                      + {4'd0, req.operand[3:0]};
  assign bcd_raw    = 9'd100 - {1'b0, bcd_dec} - {8'd0, x};
  assign bcd_borrow = !(bcd_dec == 8'd0 && !x);
  assign bcd_res    = (bcd_raw == 9'd100) ? 9'd0 : bcd_raw;
  assign bcd_neg    = bcd_res[8];
  assign bcd_abs    = bcd_neg ? (9'd0 - bcd_res) : bcd_res;
  assign bcd_mag    = bcd_abs[6:0];
  // divide by ten through the reciprocal 205/2048, exact for values below 1029
  assign bcd_prod   = {8'd0, bcd_mag} * 15'd205;
  assign bcd_q      = bcd_prod[14:11];
  assign bcd_r      = bcd_mag[3:0] - {bcd_q[2:0], 1'b0} - {bcd_q[0], 3'b000};
  assign bcd_q8     = bcd_neg ? (8'd0 - {4'd0, bcd_q}) : {4'd0, bcd_q};
  assign bcd_r8     = bcd_neg ? (8'd0 - {4'd0, bcd_r}) : {4'd0, bcd_r};
  assign bcd_v      = {bcd_q8[3:0], 4'd0} | bcd_r8;

  always_comb begin
    v = '0;
    f = flags;
    unique case (req.req_type) inside
      REQ_NEG: begin
        v       = neg_v;
        f       = nz_flags(flags, neg_v, sign);
        f[FL_X] = (u != '0);
        f[FL_V] = (u == sign);
        f[FL_C] = (u != '0);
      end
      REQ_NEGX: begin
        v       = negx_v;
        f[FL_X] = !(u == '0 && !x);
        f[FL_N] = |(negx_v & sign);
        f[FL_Z] = flags[FL_Z] && (negx_v == '0);
        f[FL_V] = (u == sign) && !x;
        f[FL_C] = !(u == '0 && !x);
      end
      REQ_NOT: begin
        v = not_v;
        f = nz_flags(flags, not_v, sign);
      end
      REQ_CLR: begin
        v       = '0;
        f       = '0;
        f[FL_X] = x;
        f[FL_Z] = 1'b1;
      end
      REQ_TST, REQ_MOVE_FLAGS: begin
        v = u;
        f = nz_flags(flags, u, sign);
      end
      REQ_NBCD: begin
        v       = {24'd0, bcd_v};
        f[FL_X] = bcd_borrow;
        f[FL_N] = bcd_v[7];
        f[FL_Z] = flags[FL_Z] && (bcd_v == 8'd0);
        f[FL_V] = flags[FL_V];
        f[FL_C] = bcd_borrow;
      end
      REQ_TAS: begin
        v = {24'd0, tas_b | 8'h80};
        f = nz_flags(flags, {24'd0, tas_b}, 32'h0000_0080);
      end
      REQ_SWAP: begin
        v = swap_v;
        f = nz_flags(flags, swap_v, 32'h8000_0000);
      end
      REQ_EXT: begin
        if (!req.op_size[1]) begin
          v = {req.operand[31:16], ext_w};
          f = nz_flags(flags, {16'd0, ext_w}, 32'h0000_8000);
        end else begin
          v = ext_l;
          f = nz_flags(flags, ext_l, 32'h8000_0000);
        end
      end
      REQ_LOAD_FLAGS: begin
        f = req.operand[FLAGS_W-1:0];
      end
      REQ_COND_TEST: begin
        v = (req.cond_code != CC_F && cond_eval(req.cond_code, flags)) ?
            32'h0000_00ff : 32'h0000_0000;
      end
      default: begin
        v = '0;
        f = flags;
      end
    endcase
  end

  assign res.value = v;
  assign res.flags = f;
  assign res.cond  = cond_eval(req.cond_code, f);

endmodule

// ----- hdl/unary_alu_with_condition_codes_unit.sv -----
// ----------------------------------------------------------------------------
// unary_alu_with_condition_codes_unit
// Single-operand ALU (NEG, NEGX, NOT, CLR, TST, NBCD, TAS, SWAP, EXT, flag
// load, condition test, move flags) with a five-bit XNZVC flag register.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | req_type, op_size, operand, cond_code
//   out     | out_valid/ out_ready | result_value, flags_out, cond_true
//
// One item per cycle while the output is not stalled; a result passes from
// the input register into the result register, which the execute pass loads.
// The flag register updates in that execute pass, so the next item already
// sees the new flags.
// Reset clears both stage valids and the flags to zero.
// A stalled output holds the result register; the input register still
// takes one more item, then in_ready drops until the output drains.
// ----------------------------------------------------------------------------
module unary_alu_with_condition_codes_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ualu_pkg::REQ_W-1:0]        req_type,
  input  logic [ualu_pkg::SIZE_W-1:0]       op_size,
  input  logic [ualu_pkg::DATA_W-1:0]       operand,
  input  logic [ualu_pkg::CC_W-1:0]         cond_code,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ualu_pkg::DATA_W-1:0]       result_value,
  output logic [ualu_pkg::FLAGS_W-1:0]      flags_out,
  output logic                              cond_true
);
  import ualu_pkg::*;

  logic               s1_valid;
  req_t               s1_req;
  logic               s1_go;
  logic               in_xfer;
  logic [FLAGS_W-1:0] flag_reg;
  res_t               exec_res;

  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;
  assign in_xfer  = in_valid && in_ready;

  ualu_exec u_exec (
    .req   (s1_req),
    .flags (flag_reg),
    .res   (exec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      flag_reg  <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
        flag_reg  <= exec_res.flags;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req.req_type  <= req_type;
      s1_req.op_size   <= op_size;
      s1_req.operand   <= operand;
      s1_req.cond_code <= cond_code;
    end
    // advance into the result register only when it is free or draining
    if (s1_go) begin
      result_value <= exec_res.value;
      flags_out    <= exec_res.flags;
      cond_true    <= exec_res.cond;
    end
  end

endmodule

// ----- hdl/ualu_chk.sv -----
// ----------------------------------------------------------------------------
// ualu_chk
// Port-level checker for the single-operand ALU: occupancy, reset and
// output hold behavior.
// ----------------------------------------------------------------------------
module ualu_chk (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [ualu_pkg::DATA_W-1:0]       result_value,
  input  logic [ualu_pkg::FLAGS_W-1:0]      flags_out,
  input  logic                              cond_true
);
  import ualu_pkg::*;

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] inflight;
  logic [1:0] inflight_next;

  assign in_xfer       = in_valid && in_ready;
  assign out_xfer      = out_valid && out_ready;
  assign inflight_next = inflight + {1'b0, in_xfer} - {1'b0, out_xfer};

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("output valid or input stalled right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != 2'd0)
    else $error("result shown with no item in flight");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    inflight != 2'd3)
    else $error("more than two items in flight");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    inflight == 2'd2 && !out_ready |-> !in_ready)
    else $error("input taken while both stages are full and output stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value)
      && $stable(flags_out) && $stable(cond_true))
    else $error("stalled result changed or dropped");

endmodule

bind unary_alu_with_condition_codes_unit ualu_chk u_ualu_chk (.*);

// ----- verif/unary_alu_with_condition_codes_unit_test.sv -----
// ----------------------------------------------------------------------------
// unary_alu_with_condition_codes_unit_test
// Self-checking bench for the single-operand ALU. A behavioral model of the
// operations and the XNZVC flag register predicts value, flags and condition
// outcome for every transfer in. Each transfer out is compared in order.
// Directed corner cases come first, then condition, flag-chain and random
// operation mixes, with bursty input traffic and a stalling receiver.
// ----------------------------------------------------------------------------
module unary_alu_with_condition_codes_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ualu_pkg::*;

  // codes outside the package enums that the fields still allow
  localparam logic [SIZE_W-1:0] SZ_LONG_ALT    = 2'd3;
  localparam logic [REQ_W-1:0]  REQ_UNUSED_LO  = 4'd12;
  localparam logic [REQ_W-1:0]  REQ_UNUSED_HI  = 4'd15;
  localparam int                CYCLE_LIMIT    = 200000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [REQ_W-1:0]  req_type = '0;
  logic [SIZE_W-1:0] op_size = '0;
  logic [DATA_W-1:0] operand = '0;
  logic [CC_W-1:0]   cond_code = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] result_value;
  logic [FLAGS_W-1:0] flags_out;
  logic              cond_true;

  res_t               pending_alu_results[$];
  logic [FLAGS_W-1:0] model_flags = '0;
  int                 fail_count = 0;
  int                 ops_sent = 0;
  int                 results_checked = 0;
  int                 burst_left = 0;
  int                 cycle_count = 0;
  int                 stall_left = 0;
  int                 stall_style = 0;

  unary_alu_with_condition_codes_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .op_size(op_size),
    .operand(operand),
    .cond_code(cond_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_value(result_value),
    .flags_out(flags_out),
    .cond_true(cond_true)
  );

  always #5 clk = ~clk;

  function automatic logic cond_holds(input logic [CC_W-1:0] cc,
                                      input logic [FLAGS_W-1:0] f);
    logic c, z, v, n;
    c = f[FL_C];
    z = f[FL_Z];
    v = f[FL_V];
    n = f[FL_N];
    case (cc)
      CC_HI: return !c && !z;
      CC_LS: return c || z;
      CC_CC: return !c;
      CC_CS: return c;
      CC_NE: return !z;
      CC_EQ: return z;
      CC_VC: return !v;
      CC_VS: return v;
      CC_PL: return !n;
      CC_MI: return n;
      CC_GE: return n == v;
      CC_LT: return n != v;
      CC_GT: return (n == v) && !z;
      CC_LE: return (n != v) || z;
      default: return 1'b1;
    endcase
  endfunction

  // keep X, set N and Z from the sized value, clear V and C
  function automatic logic [FLAGS_W-1:0] nz_flags(input logic [FLAGS_W-1:0] f,
                                                  input logic [DATA_W-1:0] v,
                                                  input logic [DATA_W-1:0] sign);
    logic [FLAGS_W-1:0] g;
    g = '0;
    g[FL_X] = f[FL_X];
    g[FL_N] = |(v & sign);
    g[FL_Z] = (v == '0);
    return g;
  endfunction

  function automatic res_t alu_predict(input logic [REQ_W-1:0] req,
                                       input logic [SIZE_W-1:0] sz,
                                       input logic [DATA_W-1:0] opd,
                                       input logic [CC_W-1:0] cc,
                                       inout logic [FLAGS_W-1:0] flags);
    logic [DATA_W-1:0]  mask, sign, u, v, w;
    logic [FLAGS_W-1:0] f;
    logic               x, zkeep, vkeep, borrow;
    int                 dec, diff, q, r;
    res_t               res;
    f = flags;
    x = flags[FL_X];
    v = '0;
    case (sz)
      SZ_BYTE: begin
        mask = 32'hff;
        sign = 32'h80;
      end
      SZ_WORD: begin
        mask = 32'hffff;
        sign = 32'h8000;
      end
      default: begin
        mask = 32'hffff_ffff;
        sign = 32'h8000_0000;
      end
    endcase
    u = opd & mask;
    case (req)
      REQ_NEG: begin
        v = (32'd0 - u) & mask;
        f = nz_flags(f, v, sign);
        f[FL_X] = 1'b0;
        f[FL_V] = (u == sign);
        if (u != '0) begin
          f[FL_C] = 1'b1;
          f[FL_X] = 1'b1;
        end
      end
      REQ_NEGX: begin
        v = (32'd0 - u - {31'd0, x}) & mask;
        zkeep = f[FL_Z];
        f = '0;
        f[FL_Z] = zkeep && (v == '0);
        f[FL_N] = |(v & sign);
        f[FL_V] = (u == sign) && !x;
        if (!(u == '0 && !x)) begin
          f[FL_C] = 1'b1;
          f[FL_X] = 1'b1;
        end
      end
      REQ_NOT: begin
        v = ~u & mask;
        f = nz_flags(f, v, sign);
      end
      REQ_CLR: begin
        v = '0;
        f = nz_flags(f, v, sign);
      end
      REQ_TST, REQ_MOVE_FLAGS: begin
        v = u;
        f = nz_flags(f, v, sign);
      end
      REQ_NBCD: begin
        // decimal digits by truncating division, also for non-BCD input
        dec = 10 * int'(opd[7:4]) + int'(opd[3:0]);
        diff = 100 - dec - int'(x);
        borrow = (diff < 100);
        if (diff >= 100) diff -= 100;
        q = diff / 10;
        r = diff % 10;
        v = ((32'(q) << 4) | 32'(r)) & 32'hff;
        zkeep = f[FL_Z];
        vkeep = f[FL_V];
        f = '0;
        f[FL_V] = vkeep;
        f[FL_Z] = zkeep && (v == '0);
        f[FL_N] = v[7];
        f[FL_C] = borrow;
        f[FL_X] = borrow;
      end
      REQ_TAS: begin
        u = opd & 32'hff;
        f = nz_flags(f, u, 32'h80);
        v = u | 32'h80;
      end
      REQ_SWAP: begin
        v = {opd[15:0], opd[31:16]};
        f = nz_flags(f, v, 32'h8000_0000);
      end
      REQ_EXT: begin
        if (sz == SZ_BYTE || sz == SZ_WORD) begin
          w = {16'd0, {8{opd[7]}}, opd[7:0]};
          v = {opd[31:16], w[15:0]};
          f = nz_flags(f, w, 32'h8000);
        end else begin
          v = {{16{opd[15]}}, opd[15:0]};
          f = nz_flags(f, v, 32'h8000_0000);
        end
      end
      REQ_LOAD_FLAGS: begin
        f = opd[FLAGS_W-1:0];
        v = '0;
      end
      REQ_COND_TEST: begin
        v = (cc != CC_F && cond_holds(cc, f)) ? 32'hff : 32'h0;
      end
      default: v = '0;
    endcase
    flags = f;
    res.value = v;
    res.flags = f;
    res.cond = cond_holds(cc, f);
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] pick_operand();
    logic [DATA_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: begin
        case ($urandom_range(0, 6))
          0: v = 32'h80;
          1: v = 32'h8000;
          2: v = 32'h8000_0000;
          3: v = 32'h7f;
          4: v = 32'hff;
          5: v = 32'hffff;
          default: v = 32'hffff_ffff;
        endcase
      end
      2: begin
        v[7:4] = 4'($urandom_range(0, 9));
        v[3:0] = 4'($urandom_range(0, 9));
      end
      3: v[7:0] = '0;
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_item(input logic [REQ_W-1:0] req, input logic [SIZE_W-1:0] sz,
                           input logic [DATA_W-1:0] opd, input logic [CC_W-1:0] cc);
    int gap;
    @(negedge clk);
    req_type = req;
    op_size = sz;
    operand = opd;
    cond_code = cc;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_alu_results.push_back(alu_predict(req, sz, opd, cc, model_flags));
    ops_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // drop valid for a random gap and scramble the idle payload
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid = 1'b0;
      operand = $urandom;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic send_random_op(input logic [REQ_W-1:0] req);
    send_item(req, SIZE_W'($urandom_range(0, 3)), pick_operand(),
              CC_W'($urandom_range(0, 15)));
  endtask

  task automatic test_corner_cases();
    send_item(REQ_LOAD_FLAGS, SZ_BYTE, 32'h0, CC_T);
    send_item(REQ_NEG, SZ_BYTE, 32'hffff_ff80, CC_VS);
    send_item(REQ_NEG, SZ_WORD, 32'h8000, CC_CS);
    send_item(REQ_NEG, SZ_LONG, 32'h8000_0000, CC_LT);
    send_item(REQ_NEG, SZ_LONG_ALT, 32'h0, CC_EQ);
    // sticky zero: Z set and a zero result must keep it
    send_item(REQ_LOAD_FLAGS, SZ_BYTE, 32'h04, CC_EQ);
    send_item(REQ_NEGX, SZ_BYTE, 32'hffff_ff00, CC_EQ);
    send_item(REQ_LOAD_FLAGS, SZ_BYTE, 32'h14, CC_EQ);
    send_item(REQ_NEGX, SZ_WORD, 32'h0, CC_NE);
    send_item(REQ_NOT, SZ_LONG, 32'hffff_ffff, CC_EQ);
    send_item(REQ_CLR, SZ_BYTE, 32'hdead_beab, CC_LS);
    send_item(REQ_TST, SZ_WORD, 32'h0000_8000, CC_MI);
    send_item(REQ_NBCD, SZ_LONG, 32'h0, CC_CS);
    send_item(REQ_NBCD, SZ_BYTE, 32'h99, CC_CC);
    send_item(REQ_NBCD, SZ_WORD, 32'hffff_ffff, CC_HI);
    send_item(REQ_TAS, SZ_LONG, 32'h0000_0100, CC_EQ);
    send_item(REQ_TAS, SZ_WORD, 32'h0000_00ff, CC_MI);
    send_item(REQ_SWAP, SZ_BYTE, 32'h8765_4321, CC_PL);
    send_item(REQ_EXT, SZ_BYTE, 32'habcd_0080, CC_MI);
    send_item(REQ_EXT, SZ_LONG, 32'h1234_8000, CC_GE);
    send_item(REQ_EXT, SZ_LONG_ALT, 32'h0000_0000, CC_GT);
    send_item(REQ_LOAD_FLAGS, SZ_BYTE, 32'hffff_ffff, CC_LE);
    send_item(REQ_COND_TEST, SZ_BYTE, 32'h0, CC_F);
    send_item(REQ_COND_TEST, SZ_BYTE, 32'h0, CC_VS);
    send_item(REQ_MOVE_FLAGS, SZ_LONG, 32'h0, CC_EQ);
    send_item(REQ_UNUSED_LO, SZ_WORD, 32'hffff_ffff, CC_T);
    send_item(REQ_UNUSED_HI, SZ_LONG_ALT, 32'h1f, CC_LE);
  endtask

  task automatic test_condition_codes();
    repeat (150) begin
      send_item(REQ_LOAD_FLAGS, SIZE_W'($urandom_range(0, 3)), $urandom,
                CC_W'($urandom_range(0, 15)));
      send_item(REQ_COND_TEST, SIZE_W'($urandom_range(0, 3)), $urandom,
                CC_W'($urandom_range(0, 15)));
    end
  endtask

  task automatic test_flag_sequences();
    int n;
    repeat (100) begin
      send_item(REQ_LOAD_FLAGS, SIZE_W'($urandom_range(0, 3)), $urandom,
                CC_W'($urandom_range(0, 15)));
      n = $urandom_range(2, 4);
      repeat (n) send_random_op(REQ_W'($urandom_range(0, 8)));
      send_item(REQ_COND_TEST, SIZE_W'($urandom_range(0, 3)), $urandom,
                CC_W'($urandom_range(0, 15)));
    end
  endtask

  task automatic test_random_ops();
    repeat (650) send_random_op(REQ_W'($urandom_range(0, 15)));
  endtask

  always @(posedge clk) begin
    res_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (pending_alu_results.size() == 0) begin
        $error("unexpected result: result_value %h flags_out %b", result_value, flags_out);
        fail_count++;
      end else begin
        exp_res = pending_alu_results.pop_front();
        results_checked++;
        if (result_value !== exp_res.value) begin
          $error("result_value: expected %h, got %h", exp_res.value, result_value);
          fail_count++;
        end
        if (flags_out !== exp_res.flags) begin
          $error("flags_out: expected %b, got %b", exp_res.flags, flags_out);
          fail_count++;
        end
        if (cond_true !== exp_res.cond) begin
          $error("cond_true: expected %b, got %b", exp_res.cond, cond_true);
          fail_count++;
        end
      end
    end
  end

  // receiver: pick a new stall style whenever the current spell runs out
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
    end
    stall_left--;
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= stall_left[2];
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_alu_results.size());
      $display("unary_alu_with_condition_codes_unit_test failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_corner_cases();
    test_condition_codes();
    test_flag_sequences();
    test_random_ops();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_alu_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("sent %0d operations over all twelve kinds, unused codes and size three;",
             ops_sent);
    $display("compared %0d results under bursty input and receiver stalls", results_checked);
    if (fail_count == 0) begin
      $display("unary_alu_with_condition_codes_unit_test passed");
    end else begin
      $display("unary_alu_with_condition_codes_unit_test failed");
    end
    $finish;
  end

endmodule
